// ===== sv/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and sizes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_AW          = $clog2(QUEUE_DEPTH);
  // Quotient bits 32 down to 0, one per divider step.
  localparam int DIV_STEPS         = 33;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] lr;
    logic [31:0] li;
    logic [31:0] rr;
    logic [31:0] ri;
    logic        dz;
  } cau_item_t;

  // Queue head as the back end sees it.
  typedef struct packed {
    logic      valid;
    cau_item_t item;
  } cau_q_t;

  // Payload of one divider step, which also carries finished results of
  // the other operations so that all items keep their order.
  typedef struct packed {
    logic [1:0]  action;
    logic        dz;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        sat;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [32:0] num_re;
    logic [32:0] num_im;
    logic [32:0] quo_re;
    logic [32:0] quo_im;
  } cau_div_t;

endpackage

// ===== sv/cau_in_if.sv =====
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: action code and two complex operands.
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] left_real;
  logic signed [31:0] left_imag;
  logic signed [31:0] right_real;
  logic signed [31:0] right_imag;

  modport source (
    output valid, action, left_real, left_imag, right_real, right_imag,
    input  ready
  );
  modport sink (
    input  valid, action, left_real, left_imag, right_real, right_imag,
    output ready
  );
endinterface

// ===== sv/cau_out_if.sv =====
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and status.
// ----------------------------------------------------------------------------
interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_real;
  logic signed [31:0] result_imag;
  logic [1:0]         status;

  modport source (
    output valid, result_real, result_imag, status,
    input  ready
  );
  modport sink (
    input  valid, result_real, result_imag, status,
    output ready
  );
endinterface

// ===== sv/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Accepts operand transfers, flags a zero divisor and queues the items.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic          clk,
  input  logic          rst,
  cau_in_if.sink        operands,
  input  logic          pop,
  output cau_pkg::cau_q_t head
);
  import cau_pkg::*;

  cau_item_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  push;
  cau_item_t             item_in;

  assign operands.ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push = operands.valid && operands.ready;

  always_comb begin
    item_in.action = operands.action;
    item_in.lr     = operands.left_real;
    item_in.li     = operands.left_imag;
    item_in.rr     = operands.right_real;
    item_in.ri     = operands.right_imag;
    item_in.dz     = (operands.right_real == '0) && (operands.right_imag == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

endmodule

// ===== sv/cau_div_step.sv =====
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division step for both result parts.
// ----------------------------------------------------------------------------
module cau_div_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  cau_pkg::cau_div_t d_in,
  output logic              valid_out,
  output cau_pkg::cau_div_t d_out
);
  import cau_pkg::*;

  logic [63:0] sh_re;
  logic [63:0] sh_im;
  logic        ge_re;
  logic        ge_im;
  cau_div_t    d_next;

  // The remainder stays below the divisor, so its top bit is free for the
  // shift.
  always_comb begin
    sh_re  = {d_in.rem_re[62:0], d_in.num_re[32]};
    sh_im  = {d_in.rem_im[62:0], d_in.num_im[32]};
    ge_re  = (sh_re >= d_in.den);
    ge_im  = (sh_im >= d_in.den);
    d_next = d_in;
    d_next.rem_re = ge_re ? sh_re - d_in.den : sh_re;
    d_next.rem_im = ge_im ? sh_im - d_in.den : sh_im;
    d_next.num_re = {d_in.num_re[31:0], 1'b0};
    d_next.num_im = {d_in.num_im[31:0], 1'b0};
    d_next.quo_re = {d_in.quo_re[31:0], ge_re};
    d_next.quo_im = {d_in.quo_im[31:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// ===== sv/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Executes queued items: products, sums, magnitudes, pipelined division,
// saturation and the output register.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::cau_q_t head,
  output logic           pop,
  cau_out_if.source      results
);
  import cau_pkg::*;

  localparam int NW = 64 + FRAC_BITS;

  logic adv;

  // Stage 1: products and add/subtract results.
  logic               v1;
  logic [1:0]         act1;
  logic               dz1;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [63:0] sq_r_full, sq_i_full;
  logic [63:0]        sq_r, sq_i;
  logic [31:0]        as_re1, as_im1;
  logic               as_sat1;

  // Stage 2: exact sums.
  logic               v2;
  logic [1:0]         act2;
  logic               dz2;
  logic signed [64:0] s_re, s_im;
  logic [63:0]        den2;
  logic [31:0]        as_re2, as_im2;
  logic               as_sat2;

  // Stage 3: sign and magnitude.
  logic               v3;
  logic [1:0]         act3;
  logic               dz3;
  logic               neg_re3, neg_im3;
  logic [63:0]        mag_re3, mag_im3;
  logic [63:0]        den3;
  logic [31:0]        as_re3, as_im3;
  logic               as_sat3;

  // Divider chain, entry 0 is stage 4.
  logic               v4;
  cau_div_t           d4_q;
  logic [DIV_STEPS:0] dv;
  cau_div_t           dd [DIV_STEPS+1];

  // Output register.
  logic               o_valid;
  logic [31:0]        o_re, o_im;
  logic [1:0]         o_status;

  assign adv = !o_valid || results.ready;
  assign pop = adv && head.valid;

  // Stage 1 combinational: add/subtract with saturation.
  logic [32:0] sum_re, sum_im;
  logic        pos_re, neg_re_a, pos_im, neg_im_a;
  always_comb begin
    if (head.item.action == ACT_SUB) begin
      sum_re = {head.item.lr[31], head.item.lr} - {head.item.rr[31], head.item.rr};
      sum_im = {head.item.li[31], head.item.li} - {head.item.ri[31], head.item.ri};
    end else begin
      sum_re = {head.item.lr[31], head.item.lr} + {head.item.rr[31], head.item.rr};
      sum_im = {head.item.li[31], head.item.li} + {head.item.ri[31], head.item.ri};
    end
    pos_re   = !sum_re[32] && sum_re[31];
    neg_re_a = sum_re[32] && !sum_re[31];
    pos_im   = !sum_im[32] && sum_im[31];
    neg_im_a = sum_im[32] && !sum_im[31];
  end

  // Squares of the divisor parts at full 64-bit width.
  assign sq_r_full = $signed(head.item.rr) * $signed(head.item.rr);
  assign sq_i_full = $signed(head.item.ri) * $signed(head.item.ri);

  always_ff @(posedge clk) begin
    if (adv) begin
      act1    <= head.item.action;
      dz1     <= head.item.dz;
      p_rr    <= $signed(head.item.lr) * $signed(head.item.rr);
      p_ii    <= $signed(head.item.li) * $signed(head.item.ri);
      p_ri    <= $signed(head.item.lr) * $signed(head.item.ri);
      p_ir    <= $signed(head.item.li) * $signed(head.item.rr);
      sq_r    <= $unsigned(sq_r_full);
      sq_i    <= $unsigned(sq_i_full);
      as_re1  <= pos_re ? POS_LIMIT : (neg_re_a ? NEG_LIMIT : sum_re[31:0]);
      as_im1  <= pos_im ? POS_LIMIT : (neg_im_a ? NEG_LIMIT : sum_im[31:0]);
      as_sat1 <= pos_re || neg_re_a || pos_im || neg_im_a;
    end
  end

  // Stage 2: real and imaginary sums for multiply or divide.
  always_ff @(posedge clk) begin
    if (adv) begin
      act2    <= act1;
      dz2     <= dz1;
      if (act1 == ACT_MUL) begin
        s_re <= {p_rr[63], p_rr} - {p_ii[63], p_ii};
        s_im <= {p_ri[63], p_ri} + {p_ir[63], p_ir};
      end else begin
        s_re <= {p_rr[63], p_rr} + {p_ii[63], p_ii};
        s_im <= {p_ir[63], p_ir} - {p_ri[63], p_ri};
      end
      den2    <= sq_r + sq_i;
      as_re2  <= as_re1;
      as_im2  <= as_im1;
      as_sat2 <= as_sat1;
    end
  end

  // Stage 3: magnitudes fit in 64 bits.
  logic [64:0] neg_s_re, neg_s_im;
  assign neg_s_re = -s_re;
  assign neg_s_im = -s_im;

  always_ff @(posedge clk) begin
    if (adv) begin
      act3    <= act2;
      dz3     <= dz2;
      neg_re3 <= s_re[64];
      neg_im3 <= s_im[64];
      mag_re3 <= s_re[64] ? neg_s_re[63:0] : s_re[63:0];
      mag_im3 <= s_im[64] ? neg_s_im[63:0] : s_im[63:0];
      den3    <= den2;
      as_re3  <= as_re2;
      as_im3  <= as_im2;
      as_sat3 <= as_sat2;
    end
  end

  // Stage 4: finish multiply, set up division.
  logic [63:0]   m_re, m_im;
  logic          msat_re, msat_im;
  logic [31:0]   mres_re, mres_im;
  logic [NW-1:0] num_re, num_im, top_re, top_im;
  cau_div_t      d4;

  always_comb begin
    m_re    = mag_re3 >> FRAC_BITS;
    m_im    = mag_im3 >> FRAC_BITS;
    msat_re = neg_re3 ? (m_re > 64'h8000_0000) : (m_re > 64'h7FFF_FFFF);
    msat_im = neg_im3 ? (m_im > 64'h8000_0000) : (m_im > 64'h7FFF_FFFF);
    mres_re = msat_re ? (neg_re3 ? NEG_LIMIT : POS_LIMIT)
                      : (neg_re3 ? -m_re[31:0] : m_re[31:0]);
    mres_im = msat_im ? (neg_im3 ? NEG_LIMIT : POS_LIMIT)
                      : (neg_im3 ? -m_im[31:0] : m_im[31:0]);
    num_re  = NW'(mag_re3) << FRAC_BITS;
    num_im  = NW'(mag_im3) << FRAC_BITS;
    top_re  = num_re >> DIV_STEPS;
    top_im  = num_im >> DIV_STEPS;

    d4.action = act3;
    d4.dz     = dz3;
    if (act3 == ACT_MUL) begin
      d4.res_re = mres_re;
      d4.res_im = mres_im;
      d4.sat    = msat_re || msat_im;
    end else begin
      d4.res_re = as_re3;
      d4.res_im = as_im3;
      d4.sat    = as_sat3;
    end
    d4.neg_re = neg_re3;
    d4.neg_im = neg_im3;
    // A quotient of 2^33 or more saturates whatever its low bits are.
    d4.ovf_re = (top_re >= NW'(den3));
    d4.ovf_im = (top_im >= NW'(den3));
    d4.den    = den3;
    d4.rem_re = top_re[63:0];
    d4.rem_im = top_im[63:0];
    d4.num_re = num_re[32:0];
    d4.num_im = num_im[32:0];
    d4.quo_re = '0;
    d4.quo_im = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_q <= d4;
    end
  end

  assign dv[0] = v4;
  assign dd[0] = d4_q;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    cau_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (dv[i]),
      .d_in     (dd[i]),
      .valid_out(dv[i+1]),
      .d_out    (dd[i+1])
    );
  end

  // Final stage: finish the quotient and pick the result.
  cau_div_t    df;
  logic        qsat_re, qsat_im;
  logic [31:0] qres_re, qres_im;
  logic [31:0] f_re, f_im;
  logic [1:0]  f_status;

  always_comb begin
    df      = dd[DIV_STEPS];
    qsat_re = df.ovf_re || df.quo_re[32] ||
              (df.neg_re ? (df.quo_re[31] && (df.quo_re[30:0] != '0)) : df.quo_re[31]);
    qsat_im = df.ovf_im || df.quo_im[32] ||
              (df.neg_im ? (df.quo_im[31] && (df.quo_im[30:0] != '0)) : df.quo_im[31]);
    qres_re = qsat_re ? (df.neg_re ? NEG_LIMIT : POS_LIMIT)
                      : (df.neg_re ? -df.quo_re[31:0] : df.quo_re[31:0]);
    qres_im = qsat_im ? (df.neg_im ? NEG_LIMIT : POS_LIMIT)
                      : (df.neg_im ? -df.quo_im[31:0] : df.quo_im[31:0]);
    if (df.action != ACT_DIV) begin
      f_re     = df.res_re;
      f_im     = df.res_im;
      f_status = df.sat ? ST_SAT : ST_OK;
    end else if (df.dz) begin
      f_re     = '0;
      f_im     = '0;
      f_status = ST_DZ;
    end else begin
      f_re     = qres_re;
      f_im     = qres_im;
      f_status = (qsat_re || qsat_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_re     <= f_re;
      o_im     <= f_im;
      o_status <= f_status;
    end
  end

  assign results.valid       = o_valid;
  assign results.result_real = o_re;
  assign results.result_imag = o_im;
  assign results.status      = o_status;

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on signed fixed point operands.
// ----------------------------------------------------------------------------
// The unit takes one operand transfer per cycle while its queue has room
// and returns one result transfer per item, in order, at a sustained rate
// of one item per clock while the result side is not stalled. From its
// operand transfer an item passes through the input queue, the register
// stages for products, exact sums, magnitudes and division setup, 33
// restoring-division steps (one quotient bit each, quotient bits 32 down
// to 0) and the output register, where its result is offered. Every
// operation passes through the division steps so that results stay in
// order. The input side is a four-entry queue, so operands are taken while
// the result side is stalled until that queue fills; the back end advances
// only when its output register is empty or being read. Multiply and
// divide truncate toward zero at FRAC_BITS fraction bits. Any part outside
// the signed 32-bit range saturates and reports overflow; a zero divisor
// gives a zero result with the divide-by-zero status.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  cau_in_if.sink    operands,
  cau_out_if.source results
);
  import cau_pkg::*;

  cau_q_t head;
  logic   pop;

  // Front end: operand transfers, zero-divisor flag, queue.
  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .operands(operands),
    .pop     (pop),
    .head    (head)
  );

  // Back end: arithmetic pipeline and output register.
  cau_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .results(results)
  );

  // The back end only takes items that the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue read while empty");

  // A divide-by-zero result carries zero in both parts.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_DZ) |->
      (results.result_real == '0 && results.result_imag == '0))
    else $error("divide-by-zero result is not zero");

  // An overflow status always comes with at least one part at a limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_SAT) |->
      (results.result_real == POS_LIMIT || results.result_real == NEG_LIMIT ||
       results.result_imag == POS_LIMIT || results.result_imag == NEG_LIMIT))
    else $error("overflow status without a saturated part");

endmodule

// ===== tb/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Watches both channels of the complex arithmetic unit, predicts each result
// from the accepted operands and compares it with the result transfers.
// ----------------------------------------------------------------------------
module cau_checker #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  cau_in_if    operands,
  cau_out_if   results,
  output int   fail_count,
  output int   pending
);
  import cau_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  status;
  } cplx_result_t;

  cplx_result_t awaited_results[$];

  // Clamps an exact value to the signed 32-bit range and flags saturation.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return POS_LIMIT;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return NEG_LIMIT;
    end
    return v[31:0];
  endfunction

  // Drops FRAC_BITS fraction bits with truncation toward zero.
  function automatic logic signed [127:0] trunc_frac(input logic signed [127:0] v);
    logic signed [127:0] mag;
    mag = (v < 0) ? -v : v;
    mag = mag >>> FRAC_BITS;
    return (v < 0) ? -mag : mag;
  endfunction

  // Exact quotient num * 2^FRAC_BITS / den, truncated toward zero.
  function automatic logic signed [127:0] frac_quotient(input logic signed [127:0] num,
                                                        input logic signed [127:0] den);
    logic signed [127:0] mag;
    mag = (num < 0) ? -num : num;
    mag = (mag <<< FRAC_BITS) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic cplx_result_t complex_result(input logic [1:0] action,
                                                  input logic signed [31:0] lr,
                                                  input logic signed [31:0] li,
                                                  input logic signed [31:0] rr,
                                                  input logic signed [31:0] ri);
    logic signed [127:0] a, b, c, d, den;
    cplx_result_t r;
    bit sat;
    a = lr;
    b = li;
    c = rr;
    d = ri;
    sat = 1'b0;
    r.status = ST_OK;
    case (action)
      ACT_ADD: begin
        r.re = clamp32(a + c, sat);
        r.im = clamp32(b + d, sat);
      end
      ACT_SUB: begin
        r.re = clamp32(a - c, sat);
        r.im = clamp32(b - d, sat);
      end
      ACT_MUL: begin
        r.re = clamp32(trunc_frac(a * c - b * d), sat);
        r.im = clamp32(trunc_frac(a * d + b * c), sat);
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.re = '0;
          r.im = '0;
          r.status = ST_DZ;
        end else begin
          r.re = clamp32(frac_quotient(a * c + b * d, den), sat);
          r.im = clamp32(frac_quotient(b * c - a * d, den), sat);
        end
      end
    endcase
    if (sat) r.status = ST_SAT;
    return r;
  endfunction

  assign pending = awaited_results.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    cplx_result_t want;
    cplx_result_t got;
    if (!rst) begin
      if (operands.valid && operands.ready)
        awaited_results.push_back(complex_result(operands.action, operands.left_real,
                                                 operands.left_imag, operands.right_real,
                                                 operands.right_imag));
      if (results.valid && results.ready) begin
        got = '{results.result_real, results.result_imag, results.status};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h status=%0d", $time,
                   got.re, got.im, got.status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.re !== want.re) begin
            $display("%0t: result_real expected %h actual %h", $time, want.re, got.re);
            fail_count++;
          end
          if (got.im !== want.im) begin
            $display("%0t: result_imag expected %h actual %h", $time, want.im, got.im);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives operand transfers into the complex arithmetic unit and gives the
// verdict; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int RANDOM_ITEMS = 1700;

  logic clk;
  logic rst;
  logic in_fire;
  int   fail_count;
  int   pending;
  int   burst_left;

  cau_in_if  operands();
  cau_out_if results();

  complex_arithmetic_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .operands (operands.sink),
    .results  (results.source)
  );

  cau_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .operands   (operands),
    .results    (results),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Records whether an operand transfer happened at each rising edge, so the
  // sender can look at it at the next falling edge without any race.
  always @(posedge clk) begin
    in_fire <= operands.valid && operands.ready;
  end

  // The receiver stalls on a pattern of its own: it keeps picking a random
  // mood of never stalling, stalling about half the time, or stalling hard.
  initial begin
    int mood;
    results.ready = 1'b0;
    forever begin
      mood = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk);
        case (mood)
          0: results.ready = 1'b1;
          1: results.ready = 1'($urandom_range(0, 1));
          default: results.ready = ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // Offers one item and returns at the falling edge after its transfer. The
  // sender works in bursts; between bursts valid drops for a random gap.
  task automatic send_operands(input logic [1:0] action, input logic [31:0] lr,
                               input logic [31:0] li, input logic [31:0] rr,
                               input logic [31:0] ri);
    if (burst_left == 0) begin
      operands.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    operands.action     = action;
    operands.left_real  = lr;
    operands.left_imag  = li;
    operands.right_real = rr;
    operands.right_imag = ri;
    operands.valid      = 1'b1;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
  endtask

  // Operand values weighted toward the interesting corners: full range,
  // small values near one, exact limits and zero.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2, 3:    return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      4:       return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      5:       return $urandom_range(0, 1) ? POS_LIMIT : NEG_LIMIT;
      6:       return 32'h0;
      default: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
    endcase
  endfunction

  initial begin
    logic [1:0] act;
    rst                 = 1'b1;
    burst_left          = 0;
    operands.valid      = 1'b0;
    operands.action     = ACT_ADD;
    operands.left_real  = '0;
    operands.left_imag  = '0;
    operands.right_real = '0;
    operands.right_imag = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed part: each operation, field limits, saturation both ways,
    // the zero divisor and the tiny quotient that truncates to zero.
    send_operands(ACT_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000);
    send_operands(ACT_ADD, POS_LIMIT, POS_LIMIT, 32'h1, 32'h0);
    send_operands(ACT_ADD, NEG_LIMIT, NEG_LIMIT, NEG_LIMIT, 32'hFFFF_FFFF);
    send_operands(ACT_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0004_0000);
    send_operands(ACT_SUB, NEG_LIMIT, POS_LIMIT, 32'h1, NEG_LIMIT);
    send_operands(ACT_SUB, POS_LIMIT, NEG_LIMIT, POS_LIMIT, NEG_LIMIT);
    send_operands(ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    send_operands(ACT_MUL, POS_LIMIT, POS_LIMIT, POS_LIMIT, POS_LIMIT);
    send_operands(ACT_MUL, NEG_LIMIT, NEG_LIMIT, NEG_LIMIT, NEG_LIMIT);
    send_operands(ACT_MUL, NEG_LIMIT, 32'h0, 32'h0001_0000, 32'h0);
    send_operands(ACT_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF);
    send_operands(ACT_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_operands(ACT_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_operands(ACT_DIV, POS_LIMIT, NEG_LIMIT, 32'h0, 32'h0);
    send_operands(ACT_DIV, POS_LIMIT, POS_LIMIT, 32'h1, 32'h0);
    send_operands(ACT_DIV, NEG_LIMIT, NEG_LIMIT, 32'h0, 32'h1);
    send_operands(ACT_DIV, 32'h1, 32'h0, POS_LIMIT, POS_LIMIT);
    send_operands(ACT_DIV, NEG_LIMIT, NEG_LIMIT, NEG_LIMIT, NEG_LIMIT);
    send_operands(ACT_DIV, 32'hFFFF_FFFF, 32'h3, 32'h0003_0000, 32'hFFFE_0000);
    send_operands(ACT_DIV, POS_LIMIT, 32'h0, NEG_LIMIT, 32'h0);

    // Hold off until the pipeline has drained completely once.
    operands.valid = 1'b0;
    while (pending != 0) @(negedge clk);

    // Random part, with a long fully-backed-to-back stretch in the middle.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      act = 2'($urandom_range(0, 3));
      if (n >= 600 && n < 800) burst_left = 10;
      send_operands(act, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    operands.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cau_pkg.sv
sv/cau_in_if.sv
sv/cau_out_if.sv
sv/cau_front.sv
sv/cau_div_step.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/tb_complex_arithmetic_unit.sv
